@@ rtl/bcd_display_scan_driver_macros.svh @@
// Assertion macros for the BCD display scan driver RTL.
`ifndef BCD_DISPLAY_SCAN_DRIVER_MACROS_SVH
`define BCD_DISPLAY_SCAN_DRIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bdsd: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define BDSD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bdsd: next-cycle property violated");

`endif

@@ rtl/bdsd_pkg.sv @@
// Shared constants and types of the BCD display scan driver.
package bdsd_pkg;

  localparam int DIGITS_PER_BANK = 6;
  localparam int SCAN_LEN        = 2 * DIGITS_PER_BANK;
  localparam int IDX_W           = (DIGITS_PER_BANK > 1) ? $clog2(DIGITS_PER_BANK) : 1;
  localparam int CNT_W           = $clog2(SCAN_LEN + 1);
  localparam int POS_EXT_W       = (CNT_W > 4) ? CNT_W : 4;
  localparam int VALUE_W         = 32;
  localparam int BCD_W           = 4;
  localparam int POS_W           = 4;

  // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT, exact for all 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_DIGIT
  } ctrl_state_e;

  typedef struct packed {
    logic             load;       // latch value and bank of a write
    logic             prime;      // first divide by ten
    logic             step;       // store one digit, divide again
    logic [IDX_W-1:0] digit_idx;  // bank slot for the digit in this step
    logic             tick;       // scan tick: capture one result
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;            // result register full and not taken
  } dp_status_t;

endpackage

@@ rtl/bdsd_ctrl.sv @@
// Controller FSM of the BCD display scan driver: handshake and digit sequencing.
module bdsd_ctrl
  import bdsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       req_type_i,
  input  dp_status_t status_i,
  output logic       in_stall_o,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             last_digit;
  logic             take;

  assign last_digit = (cnt_q == IDX_W'(DIGITS_PER_BANK - 1));
  assign take       = (state_q == ST_IDLE) && in_valid_i && !status_i.out_blocked;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && !req_type_i) state_d = ST_PRIME;
      end
      ST_PRIME: begin
        state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (last_digit) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.digit_idx = IDX_W'(DIGITS_PER_BANK - 1) - cnt_q;
    in_stall_o      = 1'b1;
    cnt_d           = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = status_i.out_blocked;
        cmd_o.load = take && !req_type_i;
        cmd_o.tick = take && req_type_i;
        cnt_d      = '0;
      end
      ST_PRIME: begin
        cmd_o.prime = 1'b1;
      end
      ST_DIGIT: begin
        cmd_o.step = 1'b1;
        cnt_d      = last_digit ? '0 : cnt_q + 1'b1;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/bdsd_datapath.sv @@
// Datapath of the BCD display scan driver: divider, digit banks, scan counter, result register.
module bdsd_datapath
  import bdsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               bank_select_i,
  input  logic               out_stall_i,
  output dp_status_t         status_o,
  output logic               out_valid_o,
  output logic               counter_reset_pulse_o,
  output logic               counter_clock_pulse_o,
  output logic [BCD_W-1:0]   bcd_lines_o,
  output logic [POS_W-1:0]   scan_position_o
);

  // divide-by-ten chain: val_q holds the running value, quo_q = val_q / 10
  logic [VALUE_W-1:0]   val_q, quo_q;
  logic                 bank_q;
  logic [VALUE_W-1:0]   mul_in;
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quo_next;
  logic [BCD_W-1:0]     digit;

  logic [BCD_W-1:0]     red_q   [DIGITS_PER_BANK];
  logic [BCD_W-1:0]     green_q [DIGITS_PER_BANK];

  logic [CNT_W-1:0]     scan_q, scan_d;
  logic [CNT_W-1:0]     pos;
  logic [CNT_W-1:0]     green_off;
  logic [POS_EXT_W-1:0] pos_ext;
  logic [BCD_W-1:0]     rd_digit;

  logic                 out_valid_q;
  logic                 rst_pulse_q, clk_pulse_q;
  logic [BCD_W-1:0]     bcd_q;
  logic [POS_W-1:0]     pos_q;

  assign mul_in   = cmd_i.prime ? val_q : quo_q;
  assign prod     = (2*VALUE_W)'(mul_in) * (2*VALUE_W)'(RECIP_TEN);
  assign quo_next = VALUE_W'(prod >> RECIP_SHIFT);

  // remainder needs only the low nibble: val - 8*quo - 2*quo, mod 16
  assign digit = val_q[BCD_W-1:0] - {quo_q[0], 3'b000} - {quo_q[2:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q  <= value_i;
      bank_q <= bank_select_i;
    end else if (cmd_i.prime) begin
      quo_q <= quo_next;
    end else if (cmd_i.step) begin
      val_q <= quo_q;
      quo_q <= quo_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS_PER_BANK; i++) begin
        red_q[i]   <= '0;
        green_q[i] <= '0;
      end
    end else if (cmd_i.step) begin
      if (bank_q) green_q[cmd_i.digit_idx] <= digit;
      else        red_q[cmd_i.digit_idx]   <= digit;
    end
  end

  // scan position; an out-of-range count reads as position zero
  assign pos       = (scan_q >= CNT_W'(SCAN_LEN)) ? '0 : scan_q;
  assign scan_d    = (pos == CNT_W'(SCAN_LEN - 1)) ? '0 : pos + 1'b1;
  assign green_off = pos - CNT_W'(DIGITS_PER_BANK);
  assign pos_ext   = POS_EXT_W'(pos);
  assign rd_digit  = (pos < CNT_W'(DIGITS_PER_BANK)) ? red_q[pos[IDX_W-1:0]]
                                                     : green_q[green_off[IDX_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.tick) begin
        scan_q      <= scan_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      rst_pulse_q <= (pos == '0);
      clk_pulse_q <= (pos != '0);
      bcd_q       <= rd_digit;
      pos_q       <= pos_ext[POS_W-1:0];
    end
  end

  assign status_o.out_blocked  = out_valid_q && out_stall_i;
  assign out_valid_o           = out_valid_q;
  assign counter_reset_pulse_o = rst_pulse_q;
  assign counter_clock_pulse_o = clk_pulse_q;
  assign bcd_lines_o           = bcd_q;
  assign scan_position_o       = pos_q;

endmodule

@@ rtl/bcd_display_scan_driver.sv @@
// Top level of the two-bank multiplexed BCD display scan driver.
// Tick: the result is registered and valid the next cycle; one tick per cycle while the result register
//   drains and no write is in progress.
// Write: load, prime, then one step per digit that stores a digit and does a reciprocal divide-by-ten.
// Reset (async, active low): both digit banks read zero, scan position zero, no result pending.
`include "bcd_display_scan_driver_macros.svh"
module bcd_display_scan_driver
  import bdsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               bank_select_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               counter_reset_pulse_o,
  output logic               counter_clock_pulse_o,
  output logic [BCD_W-1:0]   bcd_lines_o,
  output logic [POS_W-1:0]   scan_position_o
);

  // The controller owns the request handshake and walks a write through
  // prime + one step per digit. The datapath holds the value/quotient pair,
  // the two digit banks, the scan counter and the result register.
  // While a tick result is held by a stalled receiver, the request side
  // stalls for both kinds of transaction.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  bdsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  bdsd_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .value_i               (value_i),
    .bank_select_i         (bank_select_i),
    .out_stall_i           (out_stall_i),
    .status_o              (status),
    .out_valid_o           (out_valid_o),
    .counter_reset_pulse_o (counter_reset_pulse_o),
    .counter_clock_pulse_o (counter_clock_pulse_o),
    .bcd_lines_o           (bcd_lines_o),
    .scan_position_o       (scan_position_o)
  );

  logic wr_accept, tick_accept;
  assign wr_accept   = in_valid_i && !in_stall_o && !req_type_i;
  assign tick_accept = in_valid_i && !in_stall_o && req_type_i;

  // a write keeps the request side busy while its digits are produced
  `BDSD_ASSERT_NXT(a_write_busy, clk_i, rst_ni, wr_accept, in_stall_o)
  // every accepted tick transaction shows up in the result register
  `BDSD_ASSERT_NXT(a_tick_result, clk_i, rst_ni, tick_accept, out_valid_o)
  // exactly one of the two counter pulses per result
  `BDSD_ASSERT_IMP(a_pulse_excl, clk_i, rst_ni, out_valid_o,
                   counter_reset_pulse_o != counter_clock_pulse_o)
  // the reset pulse belongs to scan position zero only
  `BDSD_ASSERT_IMP(a_reset_at_zero, clk_i, rst_ni, out_valid_o && counter_reset_pulse_o,
                   scan_position_o == '0)

endmodule
